// File: rtl/core/gcea_pkg.sv
package gcea_pkg;

  // Field widths
  localparam int SIZE_W     = 9;
  localparam int CAP_W      = 32;
  localparam int ENERGY_W   = 60;
  localparam int PSUM_W     = CAP_W + 2;
  localparam int CFG_INDEX_W = 2;

  // Defaults handed to the module parameters
  localparam int DEF_MAX_X    = 256;
  localparam int DEF_MAX_Y    = 256;
  localparam int DEF_MAX_Z    = 256;
  localparam int DEF_CAP_BITS = 32;
  localparam int FIFO_DEPTH   = 2;

  // Register reset values
  localparam logic [SIZE_W-1:0]   SIZE_RESET  = 9'd256;
  localparam logic [ENERGY_W-1:0] LIMIT_RESET = {ENERGY_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_GRID_DEPTH   = 2'd2,
    REG_ENERGY_LIMIT = 2'd3
  } reg_index_t;

  // Grid dimensions as written
  typedef struct packed {
    logic [SIZE_W-1:0] nx;
    logic [SIZE_W-1:0] ny;
    logic [SIZE_W-1:0] nz;
  } grid_size_t;

  // One classified node: prefix sums of its energy terms in addition order
  typedef struct packed {
    logic              first;
    logic              done;
    logic [PSUM_W-1:0] p1;
    logic [PSUM_W-1:0] p2;
    logic [PSUM_W-1:0] p3;
    logic [PSUM_W-1:0] p4;
  } queue_item_t;

  // Clamp a size register: zero acts as one, above the maximum acts as the maximum
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    int unsigned r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/gcea_ram.sv
module gcea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; a read of the same address returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/gcea_front.sv
module gcea_front #(
  parameter int MAX_X    = gcea_pkg::DEF_MAX_X,
  parameter int MAX_Y    = gcea_pkg::DEF_MAX_Y,
  parameter int MAX_Z    = gcea_pkg::DEF_MAX_Z,
  parameter int CAP_BITS = gcea_pkg::DEF_CAP_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        node_full,
  input  logic [gcea_pkg::CAP_W-1:0]  source_cap,
  input  logic [gcea_pkg::CAP_W-1:0]  sink_cap,
  input  logic [gcea_pkg::CAP_W-1:0]  x_link_cap,
  input  logic [gcea_pkg::CAP_W-1:0]  y_link_cap,
  input  logic [gcea_pkg::CAP_W-1:0]  z_link_cap,
  input  gcea_pkg::grid_size_t        size,
  output logic                        q_push,
  output gcea_pkg::queue_item_t       q_item,
  input  logic                        q_full
);

  import gcea_pkg::*;

  localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int CW  = (CAP_BITS < CAP_W) ? CAP_BITS : CAP_W;
  localparam int PLANE_DEPTH = MAX_X * MAX_Y;
  localparam int PAW = (PLANE_DEPTH > 1) ? $clog2(PLANE_DEPTH) : 1;

  // Position and neighbour state
  logic [XW-1:0]  pos_x, pos_x_next;
  logic [YW-1:0]  pos_y, pos_y_next;
  logic [ZW-1:0]  pos_z, pos_z_next;
  logic [PAW-1:0] row_base, row_base_next;
  logic [PAW-1:0] plane_addr;
  logic [CW:0]    left_entry;

  logic [XW:0] wx;
  logic [YW:0] wy;
  logic [ZW:0] wz;
  logic        last_x, last_y, last_z;
  logic        accept;

  logic [CW-1:0] src_m, snk_m, xc_m, yc_m, zc_m;

  // Classification stage
  logic          b_valid;
  logic          b_full;
  logic [CW-1:0] b_src;
  logic [CW-1:0] b_snk;
  logic [CW:0]   b_left;
  logic          b_has_left, b_has_up, b_has_plane;
  logic          b_first, b_done;
  logic [CW:0]   row_rd, plane_rd;

  logic [CW-1:0]     t1, t2, t3, t4;
  logic [PSUM_W-1:0] p2, t34;

  assign src_m = CW'(source_cap);
  assign snk_m = CW'(sink_cap);
  assign xc_m  = CW'(x_link_cap);
  assign yc_m  = CW'(y_link_cap);
  assign zc_m  = CW'(z_link_cap);

  // Stall the input only when the classified node cannot move into the queue
  assign full   = b_valid && q_full;
  assign accept = push && !full;
  assign q_push = b_valid;

  assign wx = (XW+1)'(eff_size(size.nx, MAX_X));
  assign wy = (YW+1)'(eff_size(size.ny, MAX_Y));
  assign wz = (ZW+1)'(eff_size(size.nz, MAX_Z));

  assign last_x = ({1'b0, pos_x} + (XW+1)'(1)) >= wx;
  assign last_y = ({1'b0, pos_y} + (YW+1)'(1)) >= wy;
  assign last_z = ({1'b0, pos_z} + (ZW+1)'(1)) >= wz;

  assign plane_addr = row_base + PAW'(pos_x);

  // Advance the raster position, x fastest
  always_comb begin
    pos_x_next    = pos_x + XW'(1);
    pos_y_next    = pos_y;
    pos_z_next    = pos_z;
    row_base_next = row_base;
    if (last_x) begin
      pos_x_next = '0;
      if (!last_y) begin
        pos_y_next    = pos_y + YW'(1);
        row_base_next = row_base + PAW'(MAX_X);
      end else begin
        pos_y_next    = '0;
        row_base_next = '0;
        pos_z_next    = last_z ? '0 : pos_z + ZW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      pos_z      <= '0;
      row_base   <= '0;
      left_entry <= '0;
    end else if (accept) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      pos_z      <= pos_z_next;
      row_base   <= row_base_next;
      left_entry <= {node_full, xc_m};
    end
  end

  // Row above and previous plane: read old entry and write this node's in the same cycle
  gcea_ram #(
    .WIDTH (CW + 1),
    .DEPTH (MAX_X)
  ) u_row_store (
    .clk   (clk),
    .we    (accept),
    .waddr (pos_x),
    .wdata ({node_full, yc_m}),
    .re    (accept),
    .raddr (pos_x),
    .rdata (row_rd)
  );

  gcea_ram #(
    .WIDTH (CW + 1),
    .DEPTH (PLANE_DEPTH)
  ) u_plane_store (
    .clk   (clk),
    .we    (accept),
    .waddr (plane_addr),
    .wdata ({node_full, zc_m}),
    .re    (accept),
    .raddr (plane_addr),
    .rdata (plane_rd)
  );

  // Hold the node while the queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (!q_full) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_full      <= node_full;
      b_src       <= src_m;
      b_snk       <= snk_m;
      b_left      <= left_entry;
      b_has_left  <= (pos_x != '0);
      b_has_up    <= (pos_y != '0);
      b_has_plane <= (pos_z != '0);
      b_first     <= (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
      b_done      <= last_x && last_y && last_z;
    end
  end

  // Pick the terms and form prefix sums in addition order
  always_comb begin
    t1 = b_full ? b_snk : b_src;
    t2 = (b_has_left && (b_left[CW] != b_full)) ? b_left[CW-1:0] : '0;
    t3 = (b_has_up && (row_rd[CW] != b_full)) ? row_rd[CW-1:0] : '0;
    t4 = (b_has_plane && (plane_rd[CW] != b_full)) ? plane_rd[CW-1:0] : '0;
    p2  = PSUM_W'(t1) + PSUM_W'(t2);
    t34 = PSUM_W'(t3) + PSUM_W'(t4);
    q_item.first = b_first;
    q_item.done  = b_done;
    q_item.p1    = PSUM_W'(t1);
    q_item.p2    = p2;
    q_item.p3    = p2 + PSUM_W'(t3);
    q_item.p4    = p2 + t34;
  end

`ifndef NO_ASSERTIONS
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> b_valid)
    else $error("accepted node did not reach the classification stage");

  a_first_no_neighbour: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_first) |-> (!b_has_left && !b_has_up && !b_has_plane))
    else $error("first node of a grid carries a neighbour term");
`endif

endmodule

// File: rtl/core/gcea_fifo.sv
module gcea_fifo #(
  parameter int DEPTH = gcea_pkg::FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  full,
  input  gcea_pkg::queue_item_t in_item,
  output logic                  empty,
  input  logic                  out_pop,
  output gcea_pkg::queue_item_t out_item
);

  import gcea_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  queue_item_t    entries [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CNW-1:0] count;
  logic           do_wr, do_rd;

  assign full     = (count == CNW'(DEPTH));
  assign empty    = (count == '0);
  assign do_wr    = in_valid && !full;
  assign do_rd    = out_pop && !empty;
  assign out_item = entries[rd_ptr];

  // Store the incoming node
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + CNW'(1)))
    else $error("queue occupancy did not follow a lone write");
`endif

endmodule

// File: rtl/core/gcea_back.sv
module gcea_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  gcea_pkg::queue_item_t         q_item,
  input  logic [gcea_pkg::ENERGY_W-1:0] energy_limit,
  output logic                          empty,
  input  logic                          pop,
  output logic [gcea_pkg::ENERGY_W-1:0] energy_sum,
  output logic                          overflow,
  output logic                          grid_done
);

  import gcea_pkg::*;

  // Running state; headroom is limit minus sum, signed
  logic                       out_valid;
  logic [ENERGY_W-1:0]        sum, sum_next, s0;
  logic                       ov, ov_next, ov0;
  logic signed [ENERGY_W:0]   h, h0, h_adv, h_fresh;
  logic                       done_r;
  logic                       advance;
  logic signed [ENERGY_W:0]   e1, e2, e3, e4;
  logic [PSUM_W-1:0]          sel;

  assign advance    = !q_empty && (!out_valid || pop);
  assign q_pop      = advance;
  assign empty      = !out_valid;
  assign energy_sum = sum;
  assign overflow   = ov;
  assign grid_done  = done_r;

  assign e1 = $signed({{(ENERGY_W + 1 - PSUM_W){1'b0}}, q_item.p1});
  assign e2 = $signed({{(ENERGY_W + 1 - PSUM_W){1'b0}}, q_item.p2});
  assign e3 = $signed({{(ENERGY_W + 1 - PSUM_W){1'b0}}, q_item.p3});
  assign e4 = $signed({{(ENERGY_W + 1 - PSUM_W){1'b0}}, q_item.p4});

  assign h_fresh = $signed({1'b0, energy_limit}) - $signed({1'b0, sum});

  // Checked accumulate: stop at the first prefix that passes the headroom
  always_comb begin
    s0  = q_item.first ? '0 : sum;
    h0  = q_item.first ? $signed({1'b0, energy_limit}) : h;
    ov0 = q_item.first ? 1'b0 : ov;
    ov_next = 1'b1;
    priority if (ov0) begin
      sel = '0;
    end else if (e1 > h0) begin
      sel = '0;
    end else if (e2 > h0) begin
      sel = q_item.p1;
    end else if (e3 > h0) begin
      sel = q_item.p2;
    end else if (e4 > h0) begin
      sel = q_item.p3;
    end else begin
      sel     = q_item.p4;
      ov_next = 1'b0;
    end
    sum_next = s0 + ENERGY_W'(sel);
    h_adv    = h0 - $signed({{(ENERGY_W + 1 - PSUM_W){1'b0}}, sel});
  end

  // Load the result register; refresh headroom while no node arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum       <= '0;
      ov        <= 1'b0;
      h         <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      sum       <= sum_next;
      ov        <= ov_next;
      h         <= h_adv;
    end else begin
      if (pop) begin
        out_valid <= 1'b0;
      end
      h <= h_fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      done_r <= q_item.done;
    end
  end

`ifndef NO_ASSERTIONS
  a_frozen_after_overflow: assert property (@(posedge clk) disable iff (rst)
    (advance && !q_item.first && ov) |=> (ov && (sum == $past(sum))))
    else $error("sum moved after overflow within a grid");

  a_overflow_rises_on_node: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(advance))
    else $error("overflow raised without a node");

  a_first_bounded: assert property (@(posedge clk) disable iff (rst)
    (advance && q_item.first) |=> (sum <= $past(ENERGY_W'(q_item.p4))))
    else $error("first node of a grid did not restart the sum");
`endif

endmodule

// File: rtl/core/grid_cut_energy_accumulator.sv
// Path: accepting a node also reads the neighbour stores into the classification stage;
// from there the node passes through the queue into the result register and onto the result ports.
// Throughput: one node per cycle unless full or a result not yet popped stalls it, set by the single
// checked accumulate in the back end and one read plus one write per cycle on each neighbour store.
// Reset (rst, synchronous): clears position, sum, overflow flag, queue and result valid
// and restores the size and limit registers; the stores and grid_done are not cleared.
module grid_cut_energy_accumulator #(
  parameter int MAX_X    = gcea_pkg::DEF_MAX_X,
  parameter int MAX_Y    = gcea_pkg::DEF_MAX_Y,
  parameter int MAX_Z    = gcea_pkg::DEF_MAX_Z,
  parameter int CAP_BITS = gcea_pkg::DEF_CAP_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             node_full,
  input  logic [gcea_pkg::CAP_W-1:0]       source_cap,
  input  logic [gcea_pkg::CAP_W-1:0]       sink_cap,
  input  logic [gcea_pkg::CAP_W-1:0]       x_link_cap,
  input  logic [gcea_pkg::CAP_W-1:0]       y_link_cap,
  input  logic [gcea_pkg::CAP_W-1:0]       z_link_cap,
  output logic                             empty,
  input  logic                             pop,
  output logic [gcea_pkg::ENERGY_W-1:0]    energy_sum,
  output logic                             overflow,
  output logic                             grid_done,
  input  logic                             cfg_wen,
  input  logic [gcea_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcea_pkg::ENERGY_W-1:0]    cfg_data
);

  import gcea_pkg::*;

  logic [SIZE_W-1:0]   grid_width, grid_height, grid_depth;
  logic [ENERGY_W-1:0] energy_limit;
  grid_size_t          size;

  logic        q_push, q_full, q_empty, q_pop;
  queue_item_t q_in_item, q_out_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= SIZE_RESET;
      grid_height  <= SIZE_RESET;
      grid_depth   <= SIZE_RESET;
      energy_limit <= LIMIT_RESET;
    end else if (cfg_wen) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_WIDTH:   grid_width   <= cfg_data[SIZE_W-1:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[SIZE_W-1:0];
        REG_GRID_DEPTH:   grid_depth   <= cfg_data[SIZE_W-1:0];
        REG_ENERGY_LIMIT: energy_limit <= cfg_data;
      endcase
    end
  end

  assign size.nx = grid_width;
  assign size.ny = grid_height;
  assign size.nz = grid_depth;

  // Front: position, neighbour stores, term selection
  gcea_front #(
    .MAX_X    (MAX_X),
    .MAX_Y    (MAX_Y),
    .MAX_Z    (MAX_Z),
    .CAP_BITS (CAP_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .node_full  (node_full),
    .source_cap (source_cap),
    .sink_cap   (sink_cap),
    .x_link_cap (x_link_cap),
    .y_link_cap (y_link_cap),
    .z_link_cap (z_link_cap),
    .size       (size),
    .q_push     (q_push),
    .q_item     (q_in_item),
    .q_full     (q_full)
  );

  // Decoupling queue
  gcea_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_push),
    .full     (q_full),
    .in_item  (q_in_item),
    .empty    (q_empty),
    .out_pop  (q_pop),
    .out_item (q_out_item)
  );

  // Back: checked accumulate and result register
  gcea_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_item       (q_out_item),
    .energy_limit (energy_limit),
    .empty        (empty),
    .pop          (pop),
    .energy_sum   (energy_sum),
    .overflow     (overflow),
    .grid_done    (grid_done)
  );

endmodule
